FILE: design/hbp_pkg.sv
// Shared types, constants and the hex digit decoder of the beacon record parser.
package hbp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned ADDR_W  = 48;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned LINE_W  = 8;
    localparam int unsigned POS_W   = 5;

    // longest line kept before it is dropped up to the next end character
    localparam int unsigned MAX_LINE = 128;

    // record character positions
    localparam logic [POS_W-1:0] POS_ADDR_FIRST = 5'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LAST  = 5'd12;
    localparam logic [POS_W-1:0] POS_LEVEL      = 5'd15;
    localparam logic [POS_W-1:0] POS_TEMP_LO    = 5'd18;
    localparam logic [POS_W-1:0] POS_TEMP_HI    = 5'd20;
    localparam logic [POS_W-1:0] POS_BATT_LO    = 5'd23;
    localparam logic [POS_W-1:0] POS_BATT_HI    = 5'd25;
    localparam logic [POS_W-1:0] POS_SUM_LAST   = 5'd26;
    localparam logic [POS_W-1:0] POS_CHECK      = 5'd28;
    localparam logic [POS_W-1:0] RECORD_LEN     = 5'd29;

    localparam logic [CHAR_W-1:0] HEX_INVALID = 8'h80;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 1'b1;

    localparam logic [CHAR_W-1:0] START_CHAR_RESET = 8'd42;
    localparam logic [CHAR_W-1:0] END_CHAR_RESET   = 8'd10;

    typedef struct packed {
        logic [ADDR_W-1:0]  device_address;
        logic [LEVEL_W-1:0] signal_level;
        logic [WORD_W-1:0]  temperature_raw;
        logic [WORD_W-1:0]  battery_raw;
    } hbp_rec_t;

    // 0-9, a-f, A-F give 0..15, anything else 0x80
    function automatic logic [CHAR_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = HEX_INVALID;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        return v;
    endfunction

endpackage

FILE: design/hbp_if.sv
// Channel interfaces of the beacon record parser: character, record and configuration.
interface hbp_char_if;
    import hbp_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_char;
    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

interface hbp_rec_if;
    import hbp_pkg::*;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  device_address;
    logic [LEVEL_W-1:0] signal_level;
    logic [WORD_W-1:0]  temperature_raw;
    logic [WORD_W-1:0]  battery_raw;
    modport source (output valid, output device_address, output signal_level,
                    output temperature_raw, output battery_raw, input ready);
    modport sink   (input valid, input device_address, input signal_level,
                    input temperature_raw, input battery_raw, output ready);
endinterface

interface hbp_cfg_if;
    import hbp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CHAR_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/hbp_parse_core.sv
// Input register and line/record state update of the beacon record parser.
module hbp_parse_core
    import hbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] start_char,
    input  logic [CHAR_W-1:0] end_char,
    hbp_char_if.sink          rx,
    input  logic              res_take,
    output logic              res_valid,
    output hbp_rec_t          res_data
);

    typedef struct packed {
        logic               started;
        logic [POS_W-1:0]   pos;
        logic [CHAR_W-1:0]  xor_sum;
        logic [3:0]         high_digit;
        logic [ADDR_W-1:0]  addr;
        logic [LEVEL_W-1:0] level;
        logic [WORD_W-1:0]  temp;
        logic [WORD_W-1:0]  batt;
        logic [CHAR_W-1:0]  check;
    } rec_state_t;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic [LINE_W-1:0] len_reg, len_next;
    logic              discard_reg, discard_next;
    rec_state_t        rs_reg, rs_next;
    logic              advance;
    logic              emit;
    logic [CHAR_W-1:0] nyb;
    logic [CHAR_W-1:0] pair;

    assign advance  = in_valid_reg & res_take;
    assign rx.ready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            len_reg      <= '0;
            discard_reg  <= 1'b0;
            rs_reg       <= '0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            len_reg     <= len_next;
            discard_reg <= discard_next;
            rs_reg      <= rs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_char_reg <= rx.rx_char;
        end
    end

    assign nyb = hex_value(in_char_reg);

    always_comb
    begin
        len_next     = len_reg;
        discard_next = discard_reg;
        rs_next      = rs_reg;
        emit         = 1'b0;
        pair         = '0;
        if (advance && in_char_reg != '0)
        begin
            if (discard_reg)
            begin
                if (in_char_reg == end_char)
                begin
                    discard_next = 1'b0;
                    len_next     = '0;
                    rs_next      = '0;
                end
            end
            else if (len_reg >= LINE_W'(MAX_LINE))
            begin
                len_next     = '0;
                rs_next      = '0;
                discard_next = (in_char_reg != end_char);
            end
            else
            begin
                len_next = len_reg + 1'b1;
                if (!rs_next.started && in_char_reg == start_char)
                begin
                    rs_next         = '0;
                    rs_next.started = 1'b1;
                end
                if (rs_next.started && rs_next.pos < RECORD_LEN)
                begin
                    pair = {rs_next.high_digit, 4'b0000} | nyb;
                    if (rs_next.pos <= POS_SUM_LAST)
                    begin
                        rs_next.xor_sum = rs_next.xor_sum ^ in_char_reg;
                    end
                    if (rs_next.pos >= POS_ADDR_FIRST && rs_next.pos <= POS_ADDR_LAST
                        && !rs_next.pos[0])
                    begin
                        rs_next.addr = {rs_next.addr[ADDR_W-CHAR_W-1:0], pair};
                    end
                    else if (rs_next.pos == POS_LEVEL)
                    begin
                        rs_next.level = pair;
                    end
                    else if (rs_next.pos == POS_TEMP_LO)
                    begin
                        rs_next.temp[7:0] = pair;
                    end
                    else if (rs_next.pos == POS_TEMP_HI)
                    begin
                        rs_next.temp[15:8] = pair;
                    end
                    else if (rs_next.pos == POS_BATT_LO)
                    begin
                        rs_next.batt[7:0] = pair;
                    end
                    else if (rs_next.pos == POS_BATT_HI)
                    begin
                        rs_next.batt[15:8] = pair;
                    end
                    else if (rs_next.pos == POS_CHECK)
                    begin
                        rs_next.check = pair;
                    end
                    rs_next.high_digit = nyb[3:0];
                    rs_next.pos        = rs_next.pos + 1'b1;
                end
                if (in_char_reg == end_char)
                begin
                    emit = rs_next.started && rs_next.pos == RECORD_LEN
                           && rs_next.check == rs_next.xor_sum && rs_next.addr != '0;
                end
            end
        end
        res_data.device_address  = rs_next.addr;
        res_data.signal_level    = rs_next.level;
        res_data.temperature_raw = rs_next.temp;
        res_data.battery_raw     = rs_next.batt;
        if (advance && in_char_reg != '0 && !discard_reg
            && !(len_reg >= LINE_W'(MAX_LINE)) && in_char_reg == end_char)
        begin
            len_next = '0;
            rs_next  = '0;
        end
    end

    assign res_valid = emit;

endmodule

FILE: design/hbp_out_reg.sv
// Output register of the beacon record parser.
module hbp_out_reg
    import hbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    input  hbp_rec_t  res_data,
    output logic      res_take,
    hbp_rec_if.source rec
);

    logic     out_valid_reg;
    hbp_rec_t out_data_reg;

    // free, or the held word leaves this cycle
    assign res_take = ~out_valid_reg | rec.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign rec.valid           = out_valid_reg;
    assign rec.device_address  = out_data_reg.device_address;
    assign rec.signal_level    = out_data_reg.signal_level;
    assign rec.temperature_raw = out_data_reg.temperature_raw;
    assign rec.battery_raw     = out_data_reg.battery_raw;

endmodule

FILE: design/hex_beacon_record_parser.sv
// Top level of the hex beacon record parser: configuration registers, core and output register.
//
// Takes one received character per cycle on rx and gives one decoded beacon record on rec
// for each line that closes with end_char and holds a complete 29-character record starting
// at the first start_char, whose XOR checksum matches and whose address is nonzero. Zero
// bytes are dropped; a line of more than 128 characters is thrown away up to the next end
// character. Each character is held in the input register until the output register can take
// a result, and is then folded into the line state at the edge that also loads a finished
// record into the output register, from which the record word is offered on rec.
// Throughput is one character per cycle, sustained for as long as rec is drained;
// rx.ready falls only while a finished record waits in the output register and the core has
// another character ready to process. start_char and end_char are written through cfg,
// which is always ready, and must only be changed while no characters are in flight.
module hex_beacon_record_parser
    import hbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hbp_cfg_if.sink   cfg,
    hbp_char_if.sink  rx,
    hbp_rec_if.source rec
);

    logic [CHAR_W-1:0] start_char_reg;
    logic [CHAR_W-1:0] end_char_reg;
    logic              res_valid;
    logic              res_take;
    hbp_rec_t          res_data;

    // configuration writes always land at once
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= START_CHAR_RESET;
            end_char_reg   <= END_CHAR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_START_CHAR: start_char_reg <= cfg.data;
                REG_END_CHAR:   end_char_reg   <= cfg.data;
                default:        ;
            endcase
        end
    end

    // line assembly, record field decode and checksum
    hbp_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_char (start_char_reg),
        .end_char   (end_char_reg),
        .rx         (rx),
        .res_take   (res_take),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    // holds one finished record word while the sink stalls
    hbp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_take  (res_take),
        .rec       (rec)
    );

    // a record with a zero address is never delivered
    a_addr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rec.valid |-> rec.device_address != '0)
        else $error("record with zero address on rec");

    // the core never offers a record the output register cannot take
    a_no_lost_record: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_take)
        else $error("record offered while output register full");

    // input back-pressure only comes from a stalled output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> (rec.valid && !rec.ready))
        else $error("rx stalled without output back-pressure");

endmodule

FILE: verif/hbp_beacon_monitor.sv
// Watches the parser's channels, predicts each decoded beacon record and compares it with what comes out.
`timescale 1ns / 100ps

module hbp_beacon_monitor
    import hbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hbp_cfg_if   cfg,
    hbp_char_if  rx,
    hbp_rec_if   rec,
    output int   fail_count,
    output int   records_owed
);

    // register copies
    logic [CHAR_W-1:0] open_char;
    logic [CHAR_W-1:0] close_char;

    // line and record state
    int unsigned       line_len;
    bit                dropping;
    bit                in_rec;
    logic [POS_W-1:0]  rec_pos;
    logic [7:0]        run_xor;
    logic [7:0]        prev_nyb;
    logic [ADDR_W-1:0] addr_v;
    logic [7:0]        level_v;
    logic [15:0]       temp_v;
    logic [15:0]       batt_v;
    logic [7:0]        check_pair;

    hbp_rec_t pending_records[$];
    int       errors;

    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return c - 8'h30;
        end
        else if (lc >= 8'h61 && lc <= 8'h66)
        begin
            return lc - 8'h57;
        end
        return HEX_INVALID;
    endfunction

    task automatic clear_record();
        in_rec     = 1'b0;
        rec_pos    = '0;
        run_xor    = '0;
        prev_nyb   = '0;
        addr_v     = '0;
        level_v    = '0;
        temp_v     = '0;
        batt_v     = '0;
        check_pair = '0;
    endtask

    task automatic clear_line();
        line_len = 0;
        clear_record();
    endtask

    task automatic take_record_char(input logic [7:0] c);
        logic [7:0]  nyb;
        logic [11:0] wide;
        logic [7:0]  pair;
        nyb  = nibble_of(c);
        wide = {prev_nyb, 4'h0} | {4'h0, nyb};
        pair = wide[7:0];
        if (rec_pos <= POS_SUM_LAST)
        begin
            run_xor ^= c;
        end
        if (rec_pos >= POS_ADDR_FIRST && rec_pos <= POS_ADDR_LAST && !rec_pos[0])
        begin
            addr_v = {addr_v[ADDR_W-9:0], pair};
        end
        else
        begin
            case (rec_pos)
                POS_LEVEL:   level_v = pair;
                POS_TEMP_LO: temp_v[7:0] = pair;
                POS_TEMP_HI: temp_v[15:8] = pair;
                POS_BATT_LO: batt_v[7:0] = pair;
                POS_BATT_HI: batt_v[15:8] = pair;
                POS_CHECK:   check_pair = pair;
                default:     ;
            endcase
        end
        prev_nyb = nyb;
        rec_pos  = rec_pos + 1'b1;
    endtask

    task automatic parse_char(input logic [7:0] c);
        hbp_rec_t r;
        if (c == 8'h00)
        begin
            return;
        end
        if (dropping)
        begin
            if (c == close_char)
            begin
                dropping = 1'b0;
                clear_line();
            end
            return;
        end
        if (line_len >= MAX_LINE)
        begin
            clear_line();
            dropping = (c != close_char);
            return;
        end
        line_len++;
        if (!in_rec && c == open_char)
        begin
            clear_record();
            in_rec = 1'b1;
        end
        if (in_rec && rec_pos < RECORD_LEN)
        begin
            take_record_char(c);
        end
        if (c == close_char)
        begin
            if (in_rec && rec_pos == RECORD_LEN && check_pair == run_xor && addr_v != '0)
            begin
                r.device_address  = addr_v;
                r.signal_level    = level_v;
                r.temperature_raw = temp_v;
                r.battery_raw     = batt_v;
                pending_records.push_back(r);
            end
            clear_line();
        end
    endtask

    task automatic compare_field(input string what, input logic [ADDR_W-1:0] want_v,
                                 input logic [ADDR_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
        end
    endtask

    task automatic check_record();
        hbp_rec_t want;
        if (pending_records.size() == 0)
        begin
            errors++;
            $display("%0t: record expected none, got addr %h level %h temp %h batt %h",
                     $time, rec.device_address, rec.signal_level, rec.temperature_raw,
                     rec.battery_raw);
        end
        else
        begin
            want = pending_records.pop_front();
            compare_field("device_address", want.device_address, rec.device_address);
            compare_field("signal_level", ADDR_W'(want.signal_level), ADDR_W'(rec.signal_level));
            compare_field("temperature_raw", ADDR_W'(want.temperature_raw),
                          ADDR_W'(rec.temperature_raw));
            compare_field("battery_raw", ADDR_W'(want.battery_raw), ADDR_W'(rec.battery_raw));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_char  = START_CHAR_RESET;
            close_char = END_CHAR_RESET;
            dropping   = 1'b0;
            clear_line();
            pending_records.delete();
            errors = 0;
            fail_count   <= 0;
            records_owed <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_START_CHAR: open_char = cfg.data;
                    REG_END_CHAR:   close_char = cfg.data;
                    default:        ;
                endcase
            end
            if (rec.valid && rec.ready)
            begin
                check_record();
            end
            if (rx.valid && rx.ready)
            begin
                parse_char(rx.rx_char);
            end
            fail_count   <= errors;
            records_owed <= pending_records.size();
        end
    end

endmodule

FILE: verif/tb_hex_beacon_record_parser.sv
// Top of the beacon record parser testbench: clock, reset, character and register stimulus, verdict.
`timescale 1ns / 100ps

module tb_hex_beacon_record_parser;
    import hbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ITEM_TARGET    = 1750;
    localparam int CALM_FROM      = 1500;

    logic clk;
    logic rst_n;

    hbp_cfg_if  cfg_if ();
    hbp_char_if rx_if ();
    hbp_rec_if  rec_if ();

    int fail_count;
    int records_owed;

    hex_beacon_record_parser i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .rx    (rx_if),
        .rec   (rec_if)
    );

    hbp_beacon_monitor i_monitor
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_if),
        .rx           (rx_if),
        .rec          (rec_if),
        .fail_count   (fail_count),
        .records_owed (records_owed)
    );

    // what the stimulus believes the registers hold, used only to shape lines
    logic [CHAR_W-1:0] cur_start;
    logic [CHAR_W-1:0] cur_end;
    logic [7:0]        line_buf[$];
    int                chars_sent;
    int                records_seen;
    int                gap_rate;
    int                idle_cycles;
    bit                calm;         // no idling on either side once set
    bit                allow_upper;  // upper case hex digits in built records

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // --------------------------------------------------------------------
    // Record sink: ready drops in random bursts. The stall rate is
    // re-rolled for each new span so some stretches see no back-pressure.
    // --------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int stall_rate;
        int span;
        stall_left = 0;
        stall_rate = 0;
        span       = 0;
        rec_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                span       = 64;
                stall_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            end
            span--;
            if (stall_left == 0 && !calm && stall_rate != 0 &&
                $urandom_range(0, stall_rate) == 0)
            begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left != 0)
            begin
                rec_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rec_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rec_if.valid && rec_if.ready)
        begin
            records_seen++;
        end
    end

    // watchdog: any accepted word on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (rx_if.valid && rx_if.ready) || (rec_if.valid && rec_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_hex_beacon_record_parser NOT OK");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // --------------------------------------------------------------------
    // Character helpers
    // --------------------------------------------------------------------
    function automatic bit is_hex(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        return (c >= 8'h30 && c <= 8'h39) || (lc >= 8'h61 && lc <= 8'h66);
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'h30 + n;
        end
        if (allow_upper && $urandom_range(0, 1) == 1)
        begin
            return 8'h37 + n;
        end
        return 8'h57 + n;
    endfunction

    // nonzero byte that neither closes the line nor, unless allowed, opens a record
    function automatic logic [7:0] filler(input bit may_open);
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(1, 255));
        end
        while (c == cur_end || (!may_open && c == cur_start));
        return c;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(1, 255));
        end
        while (is_hex(c) || c == cur_end);
        return c;
    endfunction

    // separators stay in 0x20..0x2F so steering their low nibble keeps them non-hex
    function automatic logic [7:0] separator();
        logic [7:0] c;
        do
        begin
            c = 8'h20 + 8'($urandom_range(0, 15));
        end
        while (c == cur_end);
        return c;
    endfunction

    task automatic push_pair(input logic [7:0] v);
        line_buf.push_back(hex_digit(v[7:4]));
        line_buf.push_back(hex_digit(v[3:0]));
    endtask

    // --------------------------------------------------------------------
    // Builds one line holding a beacon record in line_buf.
    //   pre/post    : noise before the start character and after the record
    //   cut         : nonzero keeps only that many record characters
    //   bad_sum     : corrupt the check pair
    //   bad_digit   : one digit or separator replaced by a non-hex byte
    //   tail_on_end : end character doubles as the last check digit
    // --------------------------------------------------------------------
    task automatic build_record(input logic [ADDR_W-1:0] addr, input logic [7:0] level,
                                input logic [15:0] temp, input logic [15:0] batt,
                                input int pre, input int post, input int cut,
                                input bit bad_sum, input bit bad_digit, input bit tail_on_end);
        int         base;
        int         i;
        logic [7:0] sum;
        logic [3:0] end_nyb;
        line_buf.delete();
        repeat (pre)
        begin
            line_buf.push_back(filler(1'b0));
        end
        base = line_buf.size();
        line_buf.push_back(cur_start);
        for (i = 5; i >= 0; i--)
        begin
            push_pair(addr[i*8 +: 8]);
        end
        line_buf.push_back(separator());
        push_pair(level);
        line_buf.push_back(separator());
        push_pair(temp[7:0]);
        push_pair(temp[15:8]);
        line_buf.push_back(separator());
        push_pair(batt[7:0]);
        push_pair(batt[15:8]);
        line_buf.push_back(separator());
        if (bad_digit)
        begin
            line_buf[base + $urandom_range(1, 25)] = non_hex();
        end
        sum = 8'h00;
        for (i = base; i < base + 27; i++)
        begin
            sum ^= line_buf[i];
        end
        if (tail_on_end)
        begin
            // steer the last separator so the low check digit is the end character
            end_nyb = (cur_end >= 8'h61) ? 4'(cur_end - 8'h57) :
                      (cur_end >= 8'h41) ? 4'(cur_end - 8'h37) : 4'(cur_end - 8'h30);
            line_buf[base + 26] ^= {4'h0, sum[3:0] ^ end_nyb};
            sum = {sum[7:4], end_nyb};
        end
        if (bad_sum)
        begin
            sum ^= 8'($urandom_range(1, 255));
        end
        line_buf.push_back(hex_digit(sum[7:4]));
        if (tail_on_end)
        begin
            line_buf.push_back(cur_end);
        end
        else
        begin
            line_buf.push_back(hex_digit(sum[3:0]));
            if (cut != 0)
            begin
                line_buf = line_buf[0 : base + cut - 1];
            end
            repeat (post)
            begin
                line_buf.push_back(filler(1'b1));
            end
            line_buf.push_back(cur_end);
        end
    endtask

    // --------------------------------------------------------------------
    // Driving
    // --------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c);
        if (!calm && gap_rate != 0 && $urandom_range(0, gap_rate) == 0)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_char <= c;
        @(posedge clk);
        while (!rx_if.ready)
        begin
            @(posedge clk);
        end
        if (c != 8'h00)
        begin
            chars_sent++;
        end
    endtask

    // sends line_buf, now and then slipping in a zero byte the parser must drop
    task automatic send_line();
        case ($urandom_range(0, 2))
            0:       gap_rate = 0;
            1:       gap_rate = 3;
            default: gap_rate = 10;
        endcase
        foreach (line_buf[i])
        begin
            if (!calm && $urandom_range(0, 24) == 0)
            begin
                send_char(8'h00);
            end
            send_char(line_buf[i]);
        end
    endtask

    // stop sending and let every owed record drain out
    task automatic settle();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (records_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_chars(input logic [7:0] start_v, input logic [7:0] end_v);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_START_CHAR;
        cfg_if.data  <= start_v;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        cfg_if.index <= REG_END_CHAR;
        cfg_if.data  <= end_v;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
        cur_start = start_v;
        cur_end   = end_v;
    endtask

    task automatic random_line();
        int                pick;
        int                cut;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       temp;
        logic [15:0]       batt;
        pick = $urandom_range(0, 99);
        line_buf.delete();
        if (pick < 72)
        begin
            addr = {16'($urandom), $urandom};
            case ($urandom_range(0, 9))
                0:       addr = '1;
                1:       addr = ADDR_W'($urandom_range(1, 255));
                2:       addr = '0;
                default: ;
            endcase
            temp = 16'($urandom);
            batt = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
            if ($urandom_range(0, 7) == 0)
            begin
                temp = 16'h0000;
            end
            cut = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 28) : 0;
            build_record(addr, 8'($urandom), temp, batt, $urandom_range(0, 3),
                         (cut != 0) ? 0 : $urandom_range(0, 3), cut,
                         $urandom_range(0, 11) == 0, $urandom_range(0, 15) == 0, 1'b0);
        end
        else if (pick < 84)
        begin
            repeat ($urandom_range(0, 20))
            begin
                line_buf.push_back(filler(1'b1));
            end
            line_buf.push_back(cur_end);
        end
        else if (pick < 97)
        begin
            // raw bytes: every value, zero and both register characters included
            repeat ($urandom_range(1, 40))
            begin
                line_buf.push_back(8'($urandom));
            end
            line_buf.push_back(cur_end);
        end
        else
        begin
            repeat ($urandom_range(120, 140))
            begin
                line_buf.push_back(filler(1'b1));
            end
            line_buf.push_back(cur_end);
        end
        send_line();
    endtask

    // --------------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------------
    initial
    begin
        bit paused;
        rst_n         <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_char <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= REG_START_CHAR;
        cfg_if.data   <= '0;
        cur_start     = START_CHAR_RESET;
        cur_end       = END_CHAR_RESET;
        chars_sent    = 0;
        records_seen  = 0;
        gap_rate      = 0;
        calm          = 1'b0;
        allow_upper   = 1'b1;
        paused        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines with the reset register values
        build_record('1, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 1'b0, 1'b0, 1'b0);
        send_line();
        build_record(48'h1, 8'h00, 16'h0000, 16'h0000, 2, 2, 0, 1'b0, 1'b0, 1'b0);
        send_line();
        build_record('0, 8'h5A, 16'h1234, 16'h8001, 0, 0, 0, 1'b0, 1'b0, 1'b0);
        send_line();   // zero address, no record
        build_record(48'hA5A5_0F0F_C3C3, 8'h80, 16'h7FFF, 16'h00FF, 1, 1, 0, 1'b1, 1'b0, 1'b0);
        send_line();   // checksum broken
        build_record(48'h1234_5678_9ABC, 8'h33, 16'hBEEF, 16'hCAFE, 0, 0, 0, 1'b0, 1'b1, 1'b0);
        send_line();   // non-hex digit counts as 0x80
        build_record(48'h0000_0000_00FF, 8'h01, 16'h0100, 16'h0001, 0, 0, 20, 1'b0, 1'b0, 1'b0);
        send_line();   // line ends before the record is complete
        line_buf = {cur_end};
        send_line();   // empty line
        line_buf.delete();
        repeat (128)
        begin
            line_buf.push_back(filler(1'b1));
        end
        line_buf.push_back(cur_end);
        send_line();   // end character lands on the overflow itself
        line_buf.delete();
        repeat (135)
        begin
            line_buf.push_back(filler(1'b1));
        end
        line_buf.push_back(cur_end);
        send_line();   // overflow, then discard up to the end character
        build_record(48'h0000_0000_0001, 8'hFF, 16'hFFFF, 16'h0000, 0, 0, 0, 1'b0, 1'b0, 1'b0);
        send_line();   // parser must have recovered

        // start and end both 0xFF: the opening character closes the line at once
        settle();
        set_chars(8'hFF, 8'hFF);
        repeat (12)
        begin
            random_line();
        end

        // zero start and end: never opens, never closes, every line overflows
        settle();
        set_chars(8'h00, 8'h00);
        line_buf.delete();
        repeat (150)
        begin
            line_buf.push_back(filler(1'b1));
        end
        send_line();
        repeat (3)
        begin
            random_line();
        end

        // a common serial framing, with one full drain half way through
        settle();
        set_chars(8'h24, 8'h0D);
        while (chars_sent < 900)
        begin
            random_line();
            if (!paused && chars_sent > 500)
            begin
                settle();
                paused = 1'b1;
            end
        end

        // end character is a hex digit and closes the line as the last check digit
        settle();
        set_chars(8'h24, 8'h41);
        allow_upper = 1'b0;
        repeat (3)
        begin
            build_record({16'($urandom), $urandom}, 8'($urandom), 16'($urandom),
                         16'($urandom), $urandom_range(0, 2), 0, 0, 1'b0, 1'b0, 1'b1);
            send_line();
        end
        repeat (8)
        begin
            random_line();
        end
        allow_upper = 1'b1;

        // back to the reset values, written explicitly; last stretch runs without idling
        settle();
        set_chars(START_CHAR_RESET, END_CHAR_RESET);
        while ((chars_sent < ITEM_TARGET || records_seen < 40) && chars_sent < 6000)
        begin
            if (chars_sent >= CALM_FROM)
            begin
                calm = 1'b1;
            end
            random_line();
        end

        settle();
        if (fail_count == 0 && records_owed == 0)
        begin
            $display("tb_hex_beacon_record_parser OK");
        end
        else
        begin
            $display("tb_hex_beacon_record_parser NOT OK");
        end
        $finish;
    end

endmodule
